// ===== hdl/tcw_pkg.sv =====
// types, codes and constants shared by the text console writer modules
package tcw_pkg;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int LIN_W  = 11;
  localparam int CHAR_W = 8;

  localparam logic [1:0] FUNC_PUT  = 2'd0;
  localparam logic [1:0] FUNC_SET  = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;

  localparam logic [7:0] BLANK       = 8'h20;
  localparam logic [7:0] RESET_COLOR = 8'h07;

  typedef struct packed {
    logic [1:0]        func;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } tcw_in_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [LIN_W-1:0]  cursor_linear;
    logic [CHAR_W-1:0] cell_text;
    logic [CHAR_W-1:0] cell_color;
  } tcw_out_t;

  typedef enum logic [3:0] {
    OP_PRINT,
    OP_NEWLINE,
    OP_CR,
    OP_TAB,
    OP_BACKSPACE,
    OP_FORMFEED,
    OP_NOP,
    OP_SETCUR,
    OP_READ
  } tcw_op_t;

  typedef struct packed {
    tcw_op_t           op;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } tcw_cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_CLEAR,
    ST_RESULT
  } tcw_state_t;

endpackage

// ===== hdl/tcw_fifo.sv =====
// small register queue used between the console stages
module tcw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

// ===== hdl/tcw_front.sv =====
// front end: takes items, classifies them into commands and queues them
module tcw_front
  import tcw_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  tcw_in_t  item,
  input  logic     init_busy,
  output tcw_cmd_t cmd,
  output logic     cmd_avail,
  input  logic     cmd_pop
);

  localparam int QUEUE_DEPTH = 2;

  tcw_cmd_t                  cmd_in;
  logic                      q_full;
  logic                      q_empty;
  logic [$bits(tcw_cmd_t)-1:0] q_rdata;

  always_comb begin
    cmd_in.char_code = item.char_code;
    cmd_in.col       = item.col;
    cmd_in.row       = item.row;
    case (item.func)
      FUNC_PUT: begin
        case (item.char_code)
          CH_NL:   cmd_in.op = OP_NEWLINE;
          CH_CR:   cmd_in.op = OP_CR;
          CH_TAB:  cmd_in.op = OP_TAB;
          CH_BS:   cmd_in.op = OP_BACKSPACE;
          CH_FF:   cmd_in.op = OP_FORMFEED;
          CH_VT:   cmd_in.op = OP_NOP;
          default: cmd_in.op = OP_PRINT;
        endcase
      end
      FUNC_SET:  cmd_in.op = OP_SETCUR;
      FUNC_READ: cmd_in.op = OP_READ;
      default:   cmd_in.op = OP_NOP;
    endcase
  end

  // no items during the clearing pass after reset
  assign full = q_full || init_busy;

  tcw_fifo #(
    .WIDTH($bits(tcw_cmd_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (push && !init_busy),
    .full (q_full),
    .wdata(cmd_in),
    .pop  (cmd_pop),
    .empty(q_empty),
    .rdata(q_rdata)
  );

  assign cmd       = tcw_cmd_t'(q_rdata);
  assign cmd_avail = !q_empty;

endmodule

// ===== hdl/tcw_back.sv =====
// back end: cursor, cell store, scroll and clear sweeps, result forming
module tcw_back
  import tcw_pkg::*;
#(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  tcw_cmd_t    cmd,
  input  logic        cmd_avail,
  output logic        cmd_pop,
  input  logic [7:0]  char_color,
  output logic        init_busy,
  output logic        res_push,
  input  logic        res_full,
  output tcw_out_t    res
);

  localparam int N  = ROWS * COLUMNS;
  localparam int AW = $clog2(N);
  localparam int IW = $clog2(N + 1);
  localparam int TAB_N = 2 ** COL_W;

  typedef logic [COL_W:0] tab_lut_t [TAB_N];

  function automatic tab_lut_t tab_build();
    tab_lut_t t;
    for (int i = 0; i < TAB_N; i++) begin
      t[i] = (COL_W + 1)'((i / TAB_STOP + 1) * TAB_STOP);
    end
    return t;
  endfunction

  localparam tab_lut_t TAB_LUT = tab_build();

  tcw_state_t       state;
  tcw_state_t       state_next;

  logic [15:0]      mem [N];
  logic [15:0]      rdata;
  logic [IW-1:0]    widx;
  logic [IW-1:0]    sidx;
  logic             copy_v;
  logic [AW-1:0]    copy_addr;
  logic [COL_W-1:0] cx;
  logic [ROW_W-1:0] cy;
  logic             is_read;

  logic [COL_W:0]   nx_pre;
  logic [ROW_W:0]   ny_pre;
  logic [COL_W:0]   nx_w;
  logic [ROW_W:0]   ny_w;
  logic             scroll_need;
  logic             rd_ok;
  logic [COL_W-1:0] mcol;
  logic [ROW_W-1:0] mrow;
  logic [IW-1:0]    addr_full;
  logic [AW-1:0]    addr;

  logic             we_lo;
  logic             we_hi;
  logic [AW-1:0]    waddr;
  logic [15:0]      wdata;
  logic             rd_en;
  logic [AW-1:0]    raddr;
  logic [11:0]      lin;

  // new cursor for the command at the head of the queue
  always_comb begin
    nx_pre = {1'b0, cx};
    ny_pre = {1'b0, cy};
    case (cmd.op)
      OP_PRINT:   nx_pre = {1'b0, cx} + (COL_W + 1)'(1);
      OP_NEWLINE: begin
        nx_pre = '0;
        ny_pre = {1'b0, cy} + (ROW_W + 1)'(1);
      end
      OP_CR:      nx_pre = '0;
      OP_TAB:     nx_pre = TAB_LUT[cx];
      OP_BACKSPACE: begin
        if (cx == '0) begin
          nx_pre = (COL_W + 1)'(COLUMNS - 1);
          if (cy != '0) begin
            ny_pre = {1'b0, cy} - (ROW_W + 1)'(1);
          end
        end else begin
          nx_pre = {1'b0, cx} - (COL_W + 1)'(1);
        end
      end
      OP_FORMFEED: begin
        nx_pre = '0;
        ny_pre = '0;
      end
      OP_SETCUR: begin
        nx_pre = {1'b0, cmd.col};
        ny_pre = {1'b0, cmd.row};
      end
      default: ;
    endcase

    nx_w        = nx_pre;
    ny_w        = ny_pre;
    scroll_need = 1'b0;
    if (nx_w >= (COL_W + 1)'(COLUMNS)) begin
      nx_w = '0;
      ny_w = ny_pre + (ROW_W + 1)'(1);
    end
    if (ny_w >= (ROW_W + 1)'(ROWS)) begin
      ny_w        = (ROW_W + 1)'(ROWS - 1);
      scroll_need = 1'b1;
    end

    rd_ok = ({1'b0, cmd.col} < (COL_W + 1)'(COLUMNS)) &&
            ({1'b0, cmd.row} < (ROW_W + 1)'(ROWS));

    if (cmd.op == OP_BACKSPACE) begin
      mcol = nx_pre[COL_W-1:0];
      mrow = ny_pre[ROW_W-1:0];
    end else if (cmd.op == OP_READ) begin
      mcol = cmd.col;
      mrow = cmd.row;
    end else begin
      mcol = cx;
      mrow = cy;
    end
    addr_full = IW'(mrow) * IW'(COLUMNS) + IW'(mcol);
    addr      = addr_full[AW-1:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (widx == IW'(N - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_avail) begin
          if (scroll_need) begin
            state_next = ST_SCROLL;
          end else if (cmd.op == OP_FORMFEED) begin
            state_next = ST_CLEAR;
          end else begin
            state_next = ST_RESULT;
          end
        end
      end
      ST_SCROLL: begin
        if (sidx == IW'(N) && !copy_v) begin
          state_next = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (widx == IW'(N - 1)) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!res_full) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop  = 1'b0;
    res_push = 1'b0;
    we_lo    = 1'b0;
    we_hi    = 1'b0;
    waddr    = addr;
    wdata    = {RESET_COLOR, BLANK};
    rd_en    = 1'b0;
    raddr    = addr;
    case (state)
      ST_INIT: begin
        we_lo = 1'b1;
        we_hi = 1'b1;
        waddr = widx[AW-1:0];
      end
      ST_IDLE: begin
        if (cmd_avail) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            OP_PRINT: begin
              we_lo = 1'b1;
              we_hi = 1'b1;
              wdata = {char_color, cmd.char_code};
            end
            OP_BACKSPACE: we_lo = 1'b1;
            OP_READ:      rd_en = rd_ok;
            default: ;
          endcase
        end
      end
      ST_SCROLL: begin
        rd_en = (sidx != IW'(N));
        raddr = sidx[AW-1:0];
        we_lo = copy_v;
        we_hi = copy_v;
        waddr = copy_addr;
        wdata = rdata;
      end
      ST_CLEAR: begin
        we_lo = 1'b1;
        waddr = widx[AW-1:0];
      end
      ST_RESULT: res_push = !res_full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_INIT;
      widx    <= '0;
      sidx    <= '0;
      copy_v  <= 1'b0;
      cx      <= '0;
      cy      <= '0;
      is_read <= 1'b0;
    end else begin
      state  <= state_next;
      copy_v <= (state == ST_SCROLL) && (sidx != IW'(N));
      if (state_next == ST_CLEAR && state != ST_CLEAR) begin
        widx <= (state == ST_SCROLL) ? IW'(N - COLUMNS) : '0;
      end else if (state == ST_INIT || state == ST_CLEAR) begin
        widx <= widx + IW'(1);
      end
      if (state_next == ST_SCROLL && state == ST_IDLE) begin
        sidx <= IW'(COLUMNS);
      end else if (state == ST_SCROLL && sidx != IW'(N)) begin
        sidx <= sidx + IW'(1);
      end
      if (cmd_pop) begin
        cx      <= nx_w[COL_W-1:0];
        cy      <= ny_w[ROW_W-1:0];
        is_read <= (cmd.op == OP_READ) && rd_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    copy_addr <= AW'(sidx - IW'(COLUMNS));
  end

  always_ff @(posedge clk) begin
    if (we_lo) begin
      mem[waddr][7:0] <= wdata[7:0];
    end
    if (we_hi) begin
      mem[waddr][15:8] <= wdata[15:8];
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  assign lin                 = 12'(cy) * 12'(COLUMNS) + 12'(cx);
  assign init_busy           = (state == ST_INIT);
  assign res.cursor_col      = cx;
  assign res.cursor_row      = cy;
  assign res.cursor_linear   = lin[LIN_W-1:0];
  assign res.cell_text       = is_read ? rdata[7:0] : '0;
  assign res.cell_color      = is_read ? rdata[15:8] : '0;

`ifndef ASSERT_OFF
  a_cursor_bounded: assert property (@(posedge clk) disable iff (rst)
    (32'(cx) < COLUMNS) && (32'(cy) < ROWS))
    else $error("cursor outside the screen");

  a_waddr_range: assert property (@(posedge clk) disable iff (rst)
    (we_lo || we_hi) |-> (32'(waddr) < N))
    else $error("cell store write beyond last cell");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (rd_en && (we_lo || we_hi)) |-> (raddr != waddr))
    else $error("read and write of the same cell in one cycle");

  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> (state != ST_IDLE))
    else $error("command taken without leaving idle");
`endif

endmodule

// ===== hdl/text_console_writer.sv =====
// text console writer top level: config register, front end, back end, result queue
// result path: item into the command queue, back end idle state, result state, then the result queue
// the back end takes one command at a time; a scroll moves every row up through the cell store
// a form feed clears the text byte of every cell, one text byte cleared per cycle
// reset: synchronous; cursor to 0,0, color to 7, then a clearing pass
// writes every cell to a space with color 7 while full stays high
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  tcw_in_t     item,
  input  logic        pop,
  output logic        empty,
  output tcw_out_t    result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int RES_DEPTH = 2;

  logic [7:0]                  char_color;
  tcw_cmd_t                    cmd;
  logic                        cmd_avail;
  logic                        cmd_pop;
  logic                        init_busy;
  logic                        res_push;
  logic                        res_full;
  tcw_out_t                    res;
  logic [$bits(tcw_out_t)-1:0] res_rdata;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? '0 : {24'd0, char_color};

  always_ff @(posedge clk) begin
    if (rst) begin
      char_color <= RESET_COLOR;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      char_color <= pwdata[7:0];
    end
  end

  tcw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .init_busy(init_busy),
    .cmd      (cmd),
    .cmd_avail(cmd_avail),
    .cmd_pop  (cmd_pop)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .TAB_STOP(TAB_STOP)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_avail (cmd_avail),
    .cmd_pop   (cmd_pop),
    .char_color(char_color),
    .init_busy (init_busy),
    .res_push  (res_push),
    .res_full  (res_full),
    .res       (res)
  );

  tcw_fifo #(
    .WIDTH($bits(tcw_out_t)),
    .DEPTH(RES_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .full (res_full),
    .wdata(res),
    .pop  (pop),
    .empty(empty),
    .rdata(res_rdata)
  );

  assign result = tcw_out_t'(res_rdata);

endmodule

// ===== bench/tb_top.sv =====
// testbench for the text console writer: queue driver, result monitor and console predictor
`timescale 1ns / 100ps

module tb_top;
  import tcw_pkg::*;

  localparam int NUM_COLS  = 80;
  localparam int NUM_ROWS  = 25;
  localparam int TAB_WIDTH = 8;
  localparam int NUM_CELLS = NUM_COLS * NUM_ROWS;
  localparam int PHASE_ITEMS = 475;
  localparam longint CYCLE_LIMIT = 20_000_000;

  localparam logic [1:0] FUNC_NONE      = 2'd3;
  localparam logic [2:0] REG_CHAR_COLOR = 3'd0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  tcw_in_t     item = '0;
  logic        pop = 1'b0;
  logic        empty;
  tcw_out_t    result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  text_console_writer #(
    .COLUMNS (NUM_COLS),
    .ROWS    (NUM_ROWS),
    .TAB_STOP(TAB_WIDTH)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .pop    (pop),
    .empty  (empty),
    .result (result),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // console model state
  logic [15:0] screen_cells [0:NUM_CELLS-1];
  int          cur_x;
  int          cur_y;
  logic [7:0]  model_color;

  tcw_in_t  pending_items [$];
  tcw_out_t cursor_results [$];
  tcw_out_t got_expect;

  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     errors = 0;
  int     items_sent = 0;
  int     results_checked = 0;
  int     scroll_count = 0;
  int     clear_count = 0;
  int     read_count = 0;
  int     colors_written = 0;
  longint cycle_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void reset_console_model();
    for (int i = 0; i < NUM_CELLS; i++) screen_cells[i] = {RESET_COLOR, BLANK};
    cur_x = 0;
    cur_y = 0;
    model_color = RESET_COLOR;
  endfunction

  function automatic void blank_text(int idx);
    screen_cells[idx][7:0] = BLANK;
  endfunction

  function automatic void wrap_console();
    if (cur_x >= NUM_COLS) begin
      cur_x = 0;
      cur_y++;
    end
    if (cur_y >= NUM_ROWS) begin
      cur_y = NUM_ROWS - 1;
      for (int i = 0; i < NUM_CELLS - NUM_COLS; i++) screen_cells[i] = screen_cells[i + NUM_COLS];
      for (int c = 0; c < NUM_COLS; c++) blank_text(NUM_CELLS - NUM_COLS + c);
      scroll_count++;
    end
  endfunction

  function automatic void put_console_char(logic [7:0] ch);
    case (ch)
      CH_NL: begin
        cur_y++;
        cur_x = 0;
      end
      CH_BS: begin
        if (cur_x == 0) begin
          cur_x = NUM_COLS - 1;
          if (cur_y > 0) cur_y--;
        end else begin
          cur_x--;
        end
        blank_text(cur_y * NUM_COLS + cur_x);
      end
      CH_TAB: cur_x = (cur_x / TAB_WIDTH + 1) * TAB_WIDTH;
      CH_FF: begin
        for (int i = 0; i < NUM_CELLS; i++) blank_text(i);
        cur_x = 0;
        cur_y = 0;
        clear_count++;
      end
      CH_CR: cur_x = 0;
      CH_VT: ;
      default: begin
        screen_cells[cur_y * NUM_COLS + cur_x] = {model_color, ch};
        cur_x++;
      end
    endcase
    wrap_console();
  endfunction

  function automatic tcw_out_t predict_console(tcw_in_t it);
    tcw_out_t r;
    int idx;
    r = '0;
    case (it.func)
      FUNC_PUT: put_console_char(it.char_code);
      FUNC_SET: begin
        cur_x = int'(it.col);
        cur_y = int'(it.row);
        wrap_console();
      end
      FUNC_READ: begin
        if (int'(it.col) < NUM_COLS && int'(it.row) < NUM_ROWS) begin
          idx = int'(it.row) * NUM_COLS + int'(it.col);
          r.cell_text  = screen_cells[idx][7:0];
          r.cell_color = screen_cells[idx][15:8];
          read_count++;
        end
      end
      default: ;
    endcase
    r.cursor_col    = COL_W'(cur_x);
    r.cursor_row    = ROW_W'(cur_y);
    r.cursor_linear = LIN_W'(cur_y * NUM_COLS + cur_x);
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    cycle_count++;
    if (rst) begin
      push <= 1'b0;
    end else if (!(push && full)) begin
      if (push) begin
        cursor_results.push_back(predict_console(item));
        void'(pending_items.pop_front());
        items_sent++;
      end
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        push <= 1'b1;
        item <= pending_items[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (cursor_results.size() == 0) begin
          $display("%0t: unexpected item, got %h", $time, result);
          errors++;
        end else begin
          got_expect = cursor_results.pop_front();
          check_field("cursor_col", 32'(got_expect.cursor_col), 32'(result.cursor_col));
          check_field("cursor_row", 32'(got_expect.cursor_row), 32'(result.cursor_row));
          check_field("cursor_linear", 32'(got_expect.cursor_linear),
                      32'(result.cursor_linear));
          check_field("cell_text", 32'(got_expect.cell_text), 32'(result.cell_text));
          check_field("cell_color", 32'(got_expect.cell_color), 32'(result.cell_color));
          results_checked++;
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, cursor_results.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic add_item(logic [1:0] f, logic [7:0] ch, logic [6:0] c, logic [4:0] r);
    tcw_in_t it;
    it.func      = f;
    it.char_code = ch;
    it.col       = c;
    it.row       = r;
    pending_items.push_back(it);
  endtask

  task automatic add_random_item();
    tcw_in_t it;
    int roll;
    it.func      = FUNC_PUT;
    it.char_code = CHAR_W'($urandom_range(0, 255));
    it.col       = COL_W'($urandom);
    it.row       = ROW_W'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 62) begin
      it.func = FUNC_PUT;
    end else if (roll < 67) begin
      it.char_code = CH_NL;
    end else if (roll < 69) begin
      it.char_code = CH_CR;
    end else if (roll < 72) begin
      it.char_code = CH_TAB;
    end else if (roll < 76) begin
      it.char_code = CH_BS;
    end else if (roll < 77) begin
      it.char_code = CH_VT;
    end else if (roll < 78) begin
      it.char_code = ($urandom_range(0, 1) == 0) ? CH_FF : CH_CR;
    end else if (roll < 88) begin
      it.func = FUNC_SET;
      if ($urandom_range(0, 99) < 85) it.col = COL_W'($urandom_range(0, NUM_COLS - 1));
      if ($urandom_range(0, 99) < 85) it.row = ROW_W'($urandom_range(0, NUM_ROWS - 2));
    end else if (roll < 98) begin
      it.func = FUNC_READ;
      if ($urandom_range(0, 99) < 90) begin
        it.col = COL_W'($urandom_range(0, NUM_COLS - 1));
        it.row = ROW_W'($urandom_range(0, NUM_ROWS - 1));
      end
    end else begin
      it.func = FUNC_NONE;
    end
    pending_items.push_back(it);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (pending_items.size() != 0 || cursor_results.size() != 0 || push);
  endtask

  task automatic write_char_color(logic [7:0] color);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_CHAR_COLOR;
    pwdata  <= {16'($urandom_range(0, 16'hFFFF)), 8'($urandom_range(0, 255)), color};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    model_color = color;
    colors_written++;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {24'h0, color}) begin
      $display("%0t: char_color readback mismatch, expected %h got %h", $time, color, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [7:0] phase_color;
    reset_console_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed items at the reset color
    add_item(FUNC_READ, 8'h00, 7'd0, 5'd0);
    add_item(FUNC_PUT, 8'h41, 7'd0, 5'd0);
    add_item(FUNC_PUT, 8'hFF, 7'd127, 5'd31);
    add_item(FUNC_PUT, 8'h00, 7'd0, 5'd0);
    add_item(FUNC_READ, 8'hFF, 7'd0, 5'd0);
    add_item(FUNC_READ, 8'h00, 7'd2, 5'd0);
    add_item(FUNC_PUT, CH_TAB, 7'd0, 5'd0);
    add_item(FUNC_SET, 8'h00, 7'd79, 5'd0);
    add_item(FUNC_PUT, CH_TAB, 7'd0, 5'd0);
    add_item(FUNC_PUT, CH_BS, 7'd0, 5'd0);
    add_item(FUNC_SET, 8'h00, 7'd0, 5'd0);
    add_item(FUNC_PUT, CH_BS, 7'd0, 5'd0);
    add_item(FUNC_PUT, CH_CR, 7'd0, 5'd0);
    add_item(FUNC_PUT, CH_NL, 7'd0, 5'd0);
    add_item(FUNC_PUT, CH_VT, 7'd0, 5'd0);
    add_item(FUNC_SET, 8'h00, 7'd79, 5'd24);
    add_item(FUNC_PUT, 8'h5A, 7'd0, 5'd0);
    add_item(FUNC_READ, 8'h00, 7'd79, 5'd23);
    add_item(FUNC_SET, 8'h00, 7'd127, 5'd31);
    add_item(FUNC_READ, 8'h00, 7'd80, 5'd0);
    add_item(FUNC_READ, 8'h00, 7'd0, 5'd25);
    add_item(FUNC_READ, 8'h00, 7'd127, 5'd31);
    add_item(FUNC_NONE, 8'hFF, 7'd127, 5'd31);
    add_item(FUNC_PUT, CH_FF, 7'd0, 5'd0);
    add_item(FUNC_READ, 8'h00, 7'd79, 5'd22);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  phase_color = 8'hFF; end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  phase_color = 8'h00; end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; phase_color = 8'h80; end
        default: begin
          send_idle_pct  = 26;
          recv_stall_pct = 26;
          phase_color    = 8'($urandom_range(1, 254));
        end
      endcase
      write_char_color(phase_color);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        add_random_item();
        // hold the sender until every result is back
        if (phase == 2 && n == PHASE_ITEMS / 2) wait_drained();
      end
      wait_drained();
    end

    repeat (40) @(posedge clk);
    $display("run covered %0d items in 5 phases, %0d results checked, %0d cells read",
             items_sent, results_checked, read_count);
    $display("scrolls %0d, form feeds %0d, color writes %0d", scroll_count, clear_count,
             colors_written);
    if (errors == 0 && cursor_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/tcw_pkg.sv
hdl/tcw_fifo.sv
hdl/tcw_front.sv
hdl/tcw_back.sv
hdl/text_console_writer.sv
bench/tb_top.sv
